FILE: hw/rtl/kti_pkg.sv
// Shared types, channel codes and constants of the keyframe track interpolator.
// Used by the front end, back end and top level; depends on nothing.
`default_nettype none

package kti_pkg;

   localparam int MAX_KEYFRAMES_DEFAULT = 64;
   localparam int NUM_CHANNELS          = 15;
   localparam int CMD_QUEUE_DEPTH       = 4;

   localparam logic [3:0] CH_X     = 4'd0;
   localparam logic [3:0] CH_HOTX  = 4'd2;
   localparam logic [3:0] CH_HOTY  = 4'd3;
   localparam logic [3:0] CH_SX    = 4'd4;
   localparam logic [3:0] CH_SY    = 4'd5;
   localparam logic [3:0] CH_A     = 4'd10;
   localparam logic [3:0] CH_FRAME = 4'd11;
   localparam logic [3:0] CH_TYPE  = 4'd12;
   localparam logic [3:0] CH_BLEND = 4'd13;
   localparam logic [3:0] CH_Z     = 4'd14;
   localparam logic [3:0] CH_T     = 4'd15;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic [16:0] T_ONE = 17'h10000;

   localparam logic CSR_IDX_KEYFRAME_COUNT = 1'b0;

   typedef struct packed {
      logic              req_type;
      logic [5:0]        kf_index;
      logic [3:0]        channel;
      logic signed [31:0] value;
      logic signed [15:0] query_frame;
   } req_item_type;

   typedef struct packed {
      logic [3:0]         out_channel;
      logic signed [31:0] out_value;
      logic               found;
      logic               last;
   } rsp_item_type;

   typedef struct packed {
      logic               is_query;
      logic               wr_ok;
      logic [5:0]         kf_index;
      logic [3:0]         channel;
      logic signed [31:0] value;
      logic signed [15:0] query_frame;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PREP,
      ST_DIV,
      ST_RDA,
      ST_RDB,
      ST_CAPB,
      ST_MUL,
      ST_FIN,
      ST_MISS
   } state_type;

endpackage

`default_nettype wire

FILE: hw/rtl/kti_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Holds the keyframe words; depends on nothing.
`default_nettype none

module kti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 960,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/kti_front.sv
// Front end: accepts request items, classifies them and queues them as commands.
// Depends on kti_pkg.
`default_nettype none

module kti_front #(
   parameter int MAX_KEYFRAMES = kti_pkg::MAX_KEYFRAMES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire kti_pkg::req_item_type req_data,
   output logic                       cmd_valid,
   input  wire logic                  cmd_ready,
   output kti_pkg::cmd_type           cmd
);

   localparam int DEPTH  = kti_pkg::CMD_QUEUE_DEPTH;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   kti_pkg::cmd_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   kti_pkg::cmd_type  new_cmd;
   logic              push, pop;

   // A write is kept only when it lands inside the table.
   always_comb begin
      new_cmd.is_query    = (req_data.req_type == kti_pkg::REQ_QUERY);
      new_cmd.wr_ok       = (32'(req_data.kf_index) < MAX_KEYFRAMES) &&
                            (32'(req_data.channel) < kti_pkg::NUM_CHANNELS);
      new_cmd.kf_index    = req_data.kf_index;
      new_cmd.channel     = req_data.channel;
      new_cmd.value       = req_data.value;
      new_cmd.query_frame = req_data.query_frame;
   end

   assign req_ready = (fill_ff != FILL_W'(DEPTH));
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/kti_back.sv
// Back end: executes queued commands (table writes and queries) and drives results.
// Depends on kti_pkg; talks to the keyframe RAM through its ports.
`default_nettype none

module kti_back #(
   parameter int MAX_KEYFRAMES = kti_pkg::MAX_KEYFRAMES_DEFAULT,
   localparam int KF_W   = $clog2(MAX_KEYFRAMES),
   localparam int CNT_W  = $clog2(MAX_KEYFRAMES + 1),
   localparam int DEPTH  = MAX_KEYFRAMES * kti_pkg::NUM_CHANNELS,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  cmd_valid,
   output logic                       cmd_ready,
   input  wire kti_pkg::cmd_type      cmd,
   input  wire logic [6:0]            keyframe_count,
   output logic                       mem_we,
   output logic [ADDR_W-1:0]          mem_waddr,
   output logic [31:0]                mem_wdata,
   output logic [ADDR_W-1:0]          mem_raddr,
   input  wire logic [31:0]           mem_rdata,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output kti_pkg::rsp_item_type      rsp_data
);

   localparam logic signed [35:0] SAT_HI = 36'sd2147483647;
   localparam logic signed [35:0] SAT_LO = -36'sd2147483648;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [KF_W-1:0] kf,
                                                 input logic [3:0] ch);
      addr_of = ADDR_W'(32'(kf) * kti_pkg::NUM_CHANNELS + 32'(ch));
   endfunction

   kti_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]   n_ff, n_in;
   logic signed [31:0] frame_ff, frame_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic               pend_ff, pend_in;
   logic [KF_W-1:0]    pend_idx_ff, pend_idx_in;
   logic signed [31:0] prev_ff, prev_in;
   logic               have_ff, have_in;
   logic [KF_W-1:0]    seg_ff, seg_in;
   logic signed [31:0] fa_ff, fa_in;
   logic signed [31:0] fb_ff, fb_in;
   logic [33:0]        rem_ff, rem_in;
   logic [33:0]        span_ff, span_in;
   logic [16:0]        quo_ff, quo_in;
   logic [4:0]         step_ff, step_in;
   logic               span_zero_ff, span_zero_in;
   logic               type_a_zero_ff, type_a_zero_in;
   logic               type_b_zero_ff, type_b_zero_in;
   logic [3:0]         ch_ff, ch_in;
   logic signed [31:0] va_ff, va_in;
   logic signed [31:0] vb_ff, vb_in;
   logic signed [50:0] prod_ff, prod_in;
   logic signed [31:0] sx_ff, sx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   kti_pkg::rsp_item_type rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]   n_clip;
   logic signed [31:0] rd_word;
   logic               pend_first, pend_last, seg_match;
   logic               scan_miss, scan_break, scan_end;
   logic [KF_W-1:0]    seg_b;
   logic [16:0]        t_val;
   logic [33:0]        rem_sh;
   logic               rem_ge;
   logic signed [32:0] diff;
   logic signed [17:0] t_s;
   logic signed [35:0] lerp_sum;
   logic signed [31:0] lerp_val;
   logic signed [31:0] fin_val;
   logic               out_free;

   assign n_clip  = (32'(keyframe_count) > MAX_KEYFRAMES) ? CNT_W'(MAX_KEYFRAMES)
                                                          : CNT_W'(keyframe_count);
   assign rd_word = mem_rdata;
   assign seg_b   = KF_W'(seg_ff + 1'b1);
   assign t_val   = span_zero_ff ? '0 : quo_ff;

   // Segment scan: each frame word comes back in the cycle after its read is issued.
   assign pend_first = (pend_idx_ff == '0);
   assign pend_last  = ((CNT_W'(pend_idx_ff) + CNT_W'(1)) == n_ff);
   assign seg_match  = !pend_first && (prev_ff <= frame_ff) && (frame_ff <= rd_word);
   assign scan_miss  = pend_ff && pend_first && (frame_ff < rd_word);
   assign scan_break = pend_ff && seg_match && (frame_ff < rd_word);
   assign scan_end   = pend_ff && pend_last;

   // Restoring division, one quotient bit per cycle; the first step has no shift.
   assign rem_sh = (step_ff == '0) ? rem_ff : {rem_ff[32:0], 1'b0};
   assign rem_ge = (rem_sh >= span_ff);

   assign diff = 33'(vb_ff) - 33'(va_ff);
   assign t_s  = 18'(t_val);

   always_comb begin
      lerp_sum = 36'(va_ff) + 36'(prod_ff >>> 16);
      if (lerp_sum > SAT_HI) begin
         lerp_val = 32'h7FFFFFFF;
      end else if (lerp_sum < SAT_LO) begin
         lerp_val = 32'sh80000000;
      end else begin
         lerp_val = lerp_sum[31:0];
      end
   end

   always_comb begin
      unique case (ch_ff)
         kti_pkg::CH_HOTX, kti_pkg::CH_HOTY, kti_pkg::CH_FRAME,
         kti_pkg::CH_TYPE, kti_pkg::CH_BLEND: begin
            fin_val = va_ff;
         end
         kti_pkg::CH_Z: begin
            fin_val = vb_ff;
         end
         kti_pkg::CH_SY: begin
            if (va_ff == 0 && vb_ff == 0) begin
               fin_val = sx_ff;
            end else if (va_ff == 0) begin
               fin_val = vb_ff;
            end else if (vb_ff == 0) begin
               fin_val = va_ff;
            end else begin
               fin_val = lerp_val;
            end
         end
         kti_pkg::CH_A: begin
            if (type_a_zero_ff || (type_b_zero_ff && t_val == kti_pkg::T_ONE)) begin
               fin_val = '0;
            end else begin
               fin_val = lerp_val;
            end
         end
         kti_pkg::CH_T: begin
            fin_val = 32'(t_val);
         end
         default: begin
            fin_val = lerp_val;
         end
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kti_pkg::ST_IDLE: begin
            if (cmd_valid && cmd.is_query) begin
               state_in = (n_clip == '0) ? kti_pkg::ST_MISS : kti_pkg::ST_SCAN;
            end
         end
         kti_pkg::ST_SCAN: begin
            if (scan_miss) begin
               state_in = kti_pkg::ST_MISS;
            end else if (scan_break) begin
               state_in = kti_pkg::ST_PREP;
            end else if (scan_end) begin
               state_in = (have_ff || seg_match) ? kti_pkg::ST_PREP : kti_pkg::ST_MISS;
            end
         end
         kti_pkg::ST_PREP: state_in = kti_pkg::ST_DIV;
         kti_pkg::ST_DIV: begin
            if (step_ff == 5'd16) begin
               state_in = kti_pkg::ST_RDA;
            end
         end
         kti_pkg::ST_RDA:  state_in = kti_pkg::ST_RDB;
         kti_pkg::ST_RDB:  state_in = kti_pkg::ST_CAPB;
         kti_pkg::ST_CAPB: state_in = kti_pkg::ST_MUL;
         kti_pkg::ST_MUL:  state_in = kti_pkg::ST_FIN;
         kti_pkg::ST_FIN: begin
            if (out_free) begin
               if (ch_ff == kti_pkg::CH_T) begin
                  state_in = kti_pkg::ST_IDLE;
               end else if (ch_ff == kti_pkg::CH_Z) begin
                  state_in = kti_pkg::ST_FIN;
               end else begin
                  state_in = kti_pkg::ST_RDA;
               end
            end
         end
         kti_pkg::ST_MISS: begin
            if (out_free) begin
               state_in = kti_pkg::ST_IDLE;
            end
         end
         default: state_in = kti_pkg::ST_IDLE;
      endcase
   end

   // Outputs toward the queue and the RAM.
   always_comb begin
      cmd_ready = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = ADDR_W'(32'(cmd.kf_index) * kti_pkg::NUM_CHANNELS + 32'(cmd.channel));
      mem_wdata = cmd.value;
      mem_raddr = addr_of(seg_ff, ch_ff);
      unique case (state_ff)
         kti_pkg::ST_IDLE: begin
            cmd_ready = 1'b1;
            mem_we    = cmd_valid && !cmd.is_query && cmd.wr_ok;
         end
         kti_pkg::ST_SCAN: mem_raddr = addr_of(issue_ff[KF_W-1:0], kti_pkg::CH_FRAME);
         kti_pkg::ST_PREP: mem_raddr = addr_of(seg_ff, kti_pkg::CH_TYPE);
         kti_pkg::ST_DIV:  mem_raddr = addr_of(seg_b, kti_pkg::CH_TYPE);
         kti_pkg::ST_RDA:  mem_raddr = addr_of(seg_ff, ch_ff);
         kti_pkg::ST_RDB:  mem_raddr = addr_of(seg_b, ch_ff);
         default: begin
            mem_raddr = addr_of(seg_ff, ch_ff);
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      n_in           = n_ff;
      frame_in       = frame_ff;
      issue_in       = issue_ff;
      pend_in        = 1'b0;
      pend_idx_in    = pend_idx_ff;
      prev_in        = prev_ff;
      have_in        = have_ff;
      seg_in         = seg_ff;
      fa_in          = fa_ff;
      fb_in          = fb_ff;
      rem_in         = rem_ff;
      span_in        = span_ff;
      quo_in         = quo_ff;
      step_in        = step_ff;
      span_zero_in   = span_zero_ff;
      type_a_zero_in = type_a_zero_ff;
      type_b_zero_in = type_b_zero_ff;
      ch_in          = ch_ff;
      va_in          = va_ff;
      vb_in          = vb_ff;
      prod_in        = prod_ff;
      sx_in          = sx_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_ready ? 1'b0 : rsp_valid_ff;
      unique case (state_ff)
         kti_pkg::ST_IDLE: begin
            n_in     = n_clip;
            frame_in = 32'(cmd.query_frame);
            issue_in = '0;
            have_in  = 1'b0;
         end
         kti_pkg::ST_SCAN: begin
            if (issue_ff < n_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[KF_W-1:0];
               issue_in    = issue_ff + 1'b1;
            end
            if (pend_ff) begin
               prev_in = rd_word;
               if (seg_match) begin
                  have_in = 1'b1;
                  seg_in  = KF_W'(pend_idx_ff - 1'b1);
                  fa_in   = prev_ff;
                  fb_in   = rd_word;
               end
            end
         end
         kti_pkg::ST_PREP: begin
            span_in      = 34'(fb_ff) - 34'(fa_ff);
            rem_in       = 34'(frame_ff) - 34'(fa_ff);
            span_zero_in = (fb_ff == fa_ff);
            quo_in       = '0;
            step_in      = '0;
         end
         kti_pkg::ST_DIV: begin
            rem_in  = rem_ge ? rem_sh - span_ff : rem_sh;
            quo_in  = {quo_ff[15:0], rem_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == 5'd0) begin
               type_a_zero_in = (rd_word == 0);
            end
            if (step_ff == 5'd1) begin
               type_b_zero_in = (rd_word == 0);
            end
            ch_in = kti_pkg::CH_X;
         end
         kti_pkg::ST_RDB:  va_in   = rd_word;
         kti_pkg::ST_CAPB: vb_in   = rd_word;
         kti_pkg::ST_MUL:  prod_in = diff * t_s;
         kti_pkg::ST_FIN: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.out_channel = ch_ff;
               rsp_data_in.out_value   = fin_val;
               rsp_data_in.found       = 1'b1;
               rsp_data_in.last        = (ch_ff == kti_pkg::CH_T);
               if (ch_ff == kti_pkg::CH_SX) begin
                  sx_in = lerp_val;
               end
               ch_in = ch_ff + 1'b1;
            end
         end
         kti_pkg::ST_MISS: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.out_channel = kti_pkg::CH_X;
               rsp_data_in.out_value   = '0;
               rsp_data_in.found       = 1'b0;
               rsp_data_in.last        = 1'b1;
            end
         end
         default: begin
            rsp_data_in = rsp_data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kti_pkg::ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff           <= n_in;
      frame_ff       <= frame_in;
      issue_ff       <= issue_in;
      pend_idx_ff    <= pend_idx_in;
      prev_ff        <= prev_in;
      have_ff        <= have_in;
      seg_ff         <= seg_in;
      fa_ff          <= fa_in;
      fb_ff          <= fb_in;
      rem_ff         <= rem_in;
      span_ff        <= span_in;
      quo_ff         <= quo_in;
      step_ff        <= step_in;
      span_zero_ff   <= span_zero_in;
      type_a_zero_ff <= type_a_zero_in;
      type_b_zero_ff <= type_b_zero_in;
      ch_ff          <= ch_in;
      va_ff          <= va_in;
      vb_ff          <= vb_in;
      prod_ff        <= prod_in;
      sx_ff          <= sx_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/keyframe_track_interpolator.sv
// Top level of the keyframe track interpolator: register port, front end,
// back end and keyframe RAM. Depends on kti_pkg, kti_front, kti_back, kti_ram.
//
// The req channel carries two kinds of item. A write item stores one channel
// word of one keyframe in the track table. A query item asks for a frame; the
// block finds the bracketing segment, computes the fraction t by a restoring
// divider, and sends sixteen rsp items (channels 0 to 14, then t on channel 15,
// marked last), or one not-found item when no segment brackets the frame.
// Request items enter a four-item command queue, so req_ready stays high while
// the back end works, until that queue fills.
// A write item is done by the back end in its idle state. A query scans the
// frame words, one per cycle, from the single read port of the table RAM; the
// divider yields one quotient bit per cycle, and each interpolated channel
// needs two RAM reads, a multiply and a final add.
// Results sit in an output register; when the receiver holds rsp_ready low the
// back end waits with the next item, and the queue keeps taking requests.
// Reset clears the control state and keyframe_count; the table itself is not
// cleared, so every keyframe below keyframe_count must be written before use.
`default_nettype none

module keyframe_track_interpolator #(
   parameter int MAX_KEYFRAMES = kti_pkg::MAX_KEYFRAMES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire kti_pkg::req_item_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output kti_pkg::rsp_item_type      rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [2:0]            csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   localparam int DEPTH  = MAX_KEYFRAMES * kti_pkg::NUM_CHANNELS;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [6:0]            keyframe_count_ff, keyframe_count_in;
   logic                  csr_write;
   logic                  cmd_valid, cmd_ready;
   kti_pkg::cmd_type      cmd;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
   logic [31:0]           mem_wdata, mem_rdata;

   // The register port has no wait states. Only the keyframe count is defined;
   // writes to other addresses are dropped and reads there return zero.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      keyframe_count_in = keyframe_count_ff;
      if (csr_write && csr_paddr[2] == kti_pkg::CSR_IDX_KEYFRAME_COUNT) begin
         keyframe_count_in = csr_pwdata[6:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == kti_pkg::CSR_IDX_KEYFRAME_COUNT)
                       ? 32'(keyframe_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         keyframe_count_ff <= '0;
      end else begin
         keyframe_count_ff <= keyframe_count_in;
      end
   end

   kti_front #(
      .MAX_KEYFRAMES(MAX_KEYFRAMES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   kti_back #(
      .MAX_KEYFRAMES(MAX_KEYFRAMES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd_ready      (cmd_ready),
      .cmd            (cmd),
      .keyframe_count (keyframe_count_ff),
      .mem_we         (mem_we),
      .mem_waddr      (mem_waddr),
      .mem_wdata      (mem_wdata),
      .mem_raddr      (mem_raddr),
      .mem_rdata      (mem_rdata),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data)
   );

   kti_ram #(
      .WIDTH(32),
      .DEPTH(DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

`ifndef SYNTHESIS
   // A not-found result always closes its query.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.last)
      else $error("not-found result without last");

   // The fraction t never exceeds one in Q1.16.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found && rsp_data.out_channel == kti_pkg::CH_T
      |-> rsp_data.out_value <= 32'sd65536 && rsp_data.out_value >= 0)
      else $error("t out of range");

   // Only the fraction item ends a found query.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found
      |-> rsp_data.last == (rsp_data.out_channel == kti_pkg::CH_T))
      else $error("last flag on wrong channel");
`endif

endmodule

`default_nettype wire

FILE: tb/keyframe_track_interpolator_test.sv
// Self-checking testbench for keyframe_track_interpolator: keyframe table writes,
// segment queries, register port. Depends on kti_pkg and the block's RTL only.
`default_nettype none

module keyframe_track_interpolator_test;

   localparam int NUM_SLOTS = kti_pkg::MAX_KEYFRAMES_DEFAULT;
   localparam int CYCLE_LIMIT = 500000;
   // Long enough to cover any queued work at idle points.
   localparam int SETTLE_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   kti_pkg::req_item_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   kti_pkg::rsp_item_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   keyframe_track_interpolator i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Shadow copy of the track table and of keyframe_count.
   int track_mem [NUM_SLOTS][kti_pkg::NUM_CHANNELS];
   int kf_count;

   kti_pkg::rsp_item_type pending_rsps[$];
   int error_count = 0;
   longint cycle_count = 0;

   // Traffic shaping shared by the sender, the receiver and the test tasks.
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int rx_hold = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[keyframe_track_interpolator] ERROR");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off when a test asks for one.
   always @(posedge clock) begin
      if (rx_hold > 0) begin
         rx_hold--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Result checker: every accepted item is compared with the oldest prediction.
   always @(posedge clock) begin
      kti_pkg::rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsps.size() == 0) begin
            $display("%0t: unexpected result item %p", $time, rsp_data);
            error_count++;
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_data.out_channel !== want.out_channel) begin
               $display("%0t: out_channel expected %0d actual %0d", $time,
                        want.out_channel, rsp_data.out_channel);
               error_count++;
            end
            if (rsp_data.out_value !== want.out_value) begin
               $display("%0t: out_value (ch %0d) expected %0d actual %0d", $time,
                        want.out_channel, want.out_value, rsp_data.out_value);
               error_count++;
            end
            if (rsp_data.found !== want.found) begin
               $display("%0t: found expected %0b actual %0b", $time,
                        want.found, rsp_data.found);
               error_count++;
            end
            if (rsp_data.last !== want.last) begin
               $display("%0t: last expected %0b actual %0b", $time,
                        want.last, rsp_data.last);
               error_count++;
            end
         end
      end
   end

   function automatic int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return int'(v);
   endfunction

   // Linear blend in Q16.16 with a floored product; t is Q1.16.
   function automatic int blend_q(int a, int b, longint t);
      longint d;
      d = longint'(b) - longint'(a);
      return clamp32(longint'(a) + ((d * t) >>> 16));
   endfunction

   function automatic void push_rsp(logic [3:0] ch, int v, logic fnd, logic lst);
      kti_pkg::rsp_item_type r;
      r.out_channel = ch;
      r.out_value = v;
      r.found = fnd;
      r.last = lst;
      pending_rsps.push_back(r);
   endfunction

   // Updates the shadow table for a write item, or queues the results of a query.
   function automatic void interpolate_item(kti_pkg::req_item_type it);
      int frame, n, seg, a, b, fa, fb, sya, syb, v;
      bit hit;
      longint span, t;
      if (it.req_type == kti_pkg::REQ_WRITE) begin
         if (it.channel != kti_pkg::CH_T) track_mem[it.kf_index][it.channel] = it.value;
         return;
      end
      frame = it.query_frame;
      n = (kf_count > NUM_SLOTS) ? NUM_SLOTS : kf_count;
      hit = 0;
      seg = 0;
      if (n >= 1 && frame >= track_mem[0][kti_pkg::CH_FRAME]) begin
         for (int i = 0; i + 1 < n; i++) begin
            fa = track_mem[i][kti_pkg::CH_FRAME];
            fb = track_mem[i + 1][kti_pkg::CH_FRAME];
            if (fa <= frame && frame <= fb) begin
               hit = 1;
               seg = i;
               if (frame < fb) break;
            end
         end
      end
      if (!hit) begin
         push_rsp(kti_pkg::CH_X, 0, 1'b0, 1'b1);
         return;
      end
      a = seg;
      b = seg + 1;
      fa = track_mem[a][kti_pkg::CH_FRAME];
      fb = track_mem[b][kti_pkg::CH_FRAME];
      span = longint'(fb) - longint'(fa);
      t = (span > 0) ? ((longint'(frame) - longint'(fa)) << 16) / span : 0;
      for (int ch = 0; ch < kti_pkg::NUM_CHANNELS; ch++) begin
         if (ch == kti_pkg::CH_HOTX || ch == kti_pkg::CH_HOTY ||
             ch == kti_pkg::CH_FRAME || ch == kti_pkg::CH_TYPE ||
             ch == kti_pkg::CH_BLEND) begin
            v = track_mem[a][ch];
         end else if (ch == kti_pkg::CH_Z) begin
            v = track_mem[b][ch];
         end else begin
            v = blend_q(track_mem[a][ch], track_mem[b][ch], t);
         end
         if (ch == kti_pkg::CH_SY) begin
            // A zero Y scale borrows from the other key, or from X when both are zero.
            sya = track_mem[a][kti_pkg::CH_SY];
            syb = track_mem[b][kti_pkg::CH_SY];
            if (sya == 0 && syb == 0) begin
               v = blend_q(track_mem[a][kti_pkg::CH_SX], track_mem[b][kti_pkg::CH_SX], t);
            end else if (sya == 0) begin
               v = syb;
            end else if (syb == 0) begin
               v = sya;
            end
         end
         if (ch == kti_pkg::CH_A) begin
            // Hidden keys: the first one hides the whole segment, the second only at t = 1.
            if (track_mem[a][kti_pkg::CH_TYPE] == 0) v = 0;
            else if (track_mem[b][kti_pkg::CH_TYPE] == 0 && t >= kti_pkg::T_ONE) v = 0;
         end
         push_rsp(ch[3:0], v, 1'b1, 1'b0);
      end
      push_rsp(kti_pkg::CH_T, int'(t), 1'b1, 1'b1);
   endfunction

   // Offers one item, honoring the sender idle rate, and predicts it on acceptance.
   // Valid stays high between back-to-back items and drops only for idle cycles.
   task automatic send_item(kti_pkg::req_item_type it);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (!req_ready);
      interpolate_item(it);
   endtask

   task automatic send_write(int slot, logic [3:0] ch, int v);
      kti_pkg::req_item_type it;
      it.req_type = kti_pkg::REQ_WRITE;
      it.kf_index = slot[5:0];
      it.channel = ch;
      it.value = v;
      it.query_frame = 16'($urandom);
      send_item(it);
   endtask

   task automatic send_query(int frame);
      kti_pkg::req_item_type it;
      it.req_type = kti_pkg::REQ_QUERY;
      it.kf_index = 6'($urandom);
      it.channel = 4'($urandom);
      it.value = int'($urandom);
      it.query_frame = frame[15:0];
      send_item(it);
   endtask

   // Loads every channel of one keyframe. Fill 0 is random content, 1 all minimum,
   // 2 all maximum; frame, type and Y scale are then set as given.
   task automatic load_keyframe(int slot, int frame, int kind, int sy, int fill);
      int v;
      for (int ch = 0; ch < kti_pkg::NUM_CHANNELS; ch++) begin
         v = (fill == 1) ? 32'h80000000 : (fill == 2) ? 32'h7fffffff : int'($urandom);
         if (ch == kti_pkg::CH_FRAME) v = frame;
         if (ch == kti_pkg::CH_TYPE) v = kind;
         if (ch == kti_pkg::CH_SY) v = sy;
         send_write(slot, ch[3:0], v);
      end
   endtask

   // Lowers valid, waits out every expected result and any queued write work.
   task automatic drain();
      req_valid <= 1'b0;
      wait (pending_rsps.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(int n);
      drain();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {kti_pkg::CSR_IDX_KEYFRAME_COUNT, 2'b00};
      csr_pwdata <= n;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      kf_count = n & 32'h7f;
      @(posedge clock);
   endtask

   function automatic int rand_kind();
      return ($urandom_range(3) == 0) ? 0 : int'($urandom);
   endfunction

   function automatic int rand_sy();
      return ($urandom_range(3) == 0) ? 0 : int'($urandom);
   endfunction

   // Empty table, single keyframe, and every segment rule on a short hand-built track.
   task automatic test_directed();
      send_query(0);
      write_count(0);
      send_query(16'h8000);
      load_keyframe(0, 0, 1, 0, 0);
      write_count(1);
      send_query(0);
      // Both Y scales zero on the first segment, a zero span at frame 100, a hidden
      // first key on the third segment, and a hidden second key at the track's end.
      load_keyframe(1, 100, 5, 0, 0);
      load_keyframe(2, 100, 0, 77, 0);
      load_keyframe(3, 200, 7, 0, 0);
      load_keyframe(4, 300, 0, 12345, 0);
      write_count(5);
      send_query(-1);
      send_query(0);
      send_query(50);
      send_query(100);
      send_query(150);
      send_query(250);
      send_query(300);
      send_query(301);
      send_query(16'h7fff);
      // Channel 15 is not a table word; the write must not disturb anything.
      send_write(1, kti_pkg::CH_T, 32'hdeadbeef);
      send_query(99);
      // Frame words at the 32-bit extremes and channel values at the extremes.
      load_keyframe(0, 32'h80000000, 1, 32'h80000000, 1);
      load_keyframe(1, 32'h7fffffff, 1, 32'h7fffffff, 2);
      write_count(2);
      send_query(16'h8000);
      send_query(0);
      send_query(16'h7fff);
   endtask

   // Counts above the table size act as a full table. The first segment spans every
   // 16-bit frame, so each query stops there and reads only written slots.
   task automatic test_count_clip();
      write_count(127);
      send_query(0);
      send_query(16'h8000);
      write_count(65);
      send_query(16'h7fff);
      send_query(-5);
   endtask

   // Loads slots 0..n-1 with an ascending, occasionally unsorted, set of frames.
   task automatic build_track(int n, output int lo_frame, output int hi_frame);
      int f;
      f = int'($urandom_range(0, 4000)) - 2000;
      lo_frame = f;
      hi_frame = f;
      for (int s = 0; s < n; s++) begin
         load_keyframe(s, f, rand_kind(), rand_sy(), 0);
         if (f < lo_frame) lo_frame = f;
         if (f > hi_frame) hi_frame = f;
         if ($urandom_range(9) == 0) f = f - int'($urandom_range(0, 300));
         else if ($urandom_range(5) == 0) f = f;
         else f = f + int'($urandom_range(1, 600));
      end
   endtask

   task automatic random_query(int lo_frame, int hi_frame);
      if ($urandom_range(9) == 0) begin
         send_query(int'($urandom));
      end else begin
         send_query(int'($urandom_range(0, hi_frame - lo_frame + 40)) + lo_frame - 20);
      end
   endtask

   // One small random track, then a mix of queries and stray table writes.
   task automatic test_random(int num_items);
      int n, lo_frame, hi_frame;
      n = int'($urandom_range(3, 5));
      build_track(n, lo_frame, hi_frame);
      write_count(n);
      repeat (num_items) begin
         if ($urandom_range(4) == 0) begin
            send_write(int'($urandom_range(0, n - 1)), 4'($urandom_range(0, 15)),
                       int'($urandom));
         end else begin
            random_query(lo_frame, hi_frame);
         end
      end
   endtask

   // The receiver holds off long enough for the command queue to fill and stall
   // the sender; afterward the sender waits until every result has arrived.
   task automatic test_backpressure();
      int lo_frame, hi_frame;
      build_track(4, lo_frame, hi_frame);
      write_count(4);
      rx_hold = 800;
      repeat (10) random_query(lo_frame, hi_frame);
      drain();
      repeat (4) random_query(lo_frame, hi_frame);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      tx_idle_pct = 34;
      rx_idle_pct = 45;
      test_directed();
      test_count_clip();
      test_random(14);
      tx_idle_pct = 45;
      rx_idle_pct = 34;
      test_random(14);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_backpressure();
      test_random(14);
      drain();
      if (error_count == 0) begin
         $display("[keyframe_track_interpolator] OK");
      end else begin
         $display("[keyframe_track_interpolator] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
